### rtl/cse_pkg.sv
// Shared types, character constants and the per-byte escape encoder for the
// C string escape encoder. No dependencies.
`default_nettype none

package cse_pkg;

  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_SEVEN  = 8'h37;
  localparam logic [7:0] CHAR_BSLASH = 8'h5C;
  localparam logic [7:0] NO_LETTER   = 8'h00;

  localparam int QUEUE_DEPTH = 4;

  // One encoded byte: up to four output characters, sent chars[0] first.
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [2:0]      len;
    logic            last;
  } job_t;

  typedef struct packed {
    logic [1:0] cnt;
    job_t       first;
    job_t       second;
  } push_t;

  function automatic logic [7:0] letter_escape(input logic [7:0] c);
    logic [7:0] e;
    case (c)
      8'h09:   e = 8'h74;
      8'h0B:   e = 8'h76;
      8'h08:   e = 8'h62;
      8'h0D:   e = 8'h72;
      8'h0C:   e = 8'h66;
      8'h07:   e = 8'h61;
      8'h0A:   e = 8'h6E;
      8'h5C:   e = 8'h5C;
      8'h27:   e = 8'h27;
      8'h22:   e = 8'h22;
      default: e = NO_LETTER;
    endcase
    return e;
  endfunction

  function automatic logic is_octal_digit(input logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_SEVEN);
  endfunction

  function automatic job_t encode_job(input logic [7:0] c, input logic full,
                                      input logic last);
    job_t       j;
    logic [7:0] e;
    logic [7:0] d2;
    logic [7:0] d1;
    logic [7:0] d0;
    e  = letter_escape(c);
    d2 = CHAR_ZERO + {6'd0, c[7:6]};
    d1 = CHAR_ZERO + {5'd0, c[5:3]};
    d0 = CHAR_ZERO + {5'd0, c[2:0]};
    j.last     = last;
    j.chars    = '0;
    j.chars[0] = CHAR_BSLASH;
    if (e != NO_LETTER) begin
      j.chars[1] = e;
      j.len      = 3'd2;
    end else if (c inside {[8'h20:8'h7E]}) begin
      j.chars[0] = c;
      j.len      = 3'd1;
    end else if (full || (c[7:6] != 2'd0)) begin
      j.chars[1] = d2;
      j.chars[2] = d1;
      j.chars[3] = d0;
      j.len      = 3'd4;
    end else if (c[5:3] != 3'd0) begin
      j.chars[1] = d1;
      j.chars[2] = d0;
      j.len      = 3'd3;
    end else begin
      j.chars[1] = d0;
      j.len      = 3'd2;
    end
    return j;
  endfunction

endpackage

`default_nettype wire

### rtl/cse_in_if.sv
// Input channel of the escape encoder: raw string bytes with an end mark.
// No dependencies.
`default_nettype none

interface cse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_string;

  modport source (output valid, output in_byte, output end_of_string, input ready);
  modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

### rtl/cse_out_if.sv
// Output channel of the escape encoder: escaped characters with a run mark.
// No dependencies.
`default_nettype none

interface cse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;

  modport source (output valid, output out_byte, output run_last, input ready);
  modport sink   (input valid, input out_byte, input run_last, output ready);
endinterface

`default_nettype wire

### rtl/cse_front.sv
// Front end: accepts input words, keeps the one-byte lookahead and turns
// bytes into encoded jobs for the queue. Uses cse_pkg and cse_in_if.
`default_nettype none

module cse_front (
  input  wire logic          clk,
  input  wire logic          rst,
  cse_in_if.sink             raw,
  input  wire logic          room,
  output cse_pkg::push_t     push
);

  logic          held_valid;
  logic [7:0]    held_byte;
  logic          accept;
  cse_pkg::job_t job_a;
  cse_pkg::job_t job_b;

  assign raw.ready = room;
  assign accept    = raw.valid && room;

  always_comb begin
    job_a = cse_pkg::encode_job(held_byte, cse_pkg::is_octal_digit(raw.in_byte),
                                !raw.end_of_string);
    job_b = cse_pkg::encode_job(raw.in_byte, 1'b0, 1'b1);
    push.cnt    = 2'd0;
    push.first  = job_b;
    push.second = job_b;
    if (accept) begin
      if (held_valid) begin
        push.first = job_a;
        push.cnt   = raw.end_of_string ? 2'd2 : 2'd1;
      end else begin
        push.cnt   = raw.end_of_string ? 2'd1 : 2'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_byte  <= 8'd0;
    end else if (accept) begin
      held_valid <= !raw.end_of_string;
      held_byte  <= raw.end_of_string ? 8'd0 : raw.in_byte;
    end
  end

endmodule

`default_nettype wire

### rtl/cse_queue.sv
// Job queue between front and back: takes up to two jobs a cycle, gives
// one. Uses cse_pkg.
`default_nettype none

module cse_queue #(
  parameter int DEPTH = cse_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire cse_pkg::push_t  push,
  output logic                 room,
  output logic                 head_valid,
  output cse_pkg::job_t        head,
  input  wire logic            pop
);

  localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cse_pkg::job_t mem [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW-1:0] wptr_inc;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wptr_inc   = inc(wptr);
  assign room       = count <= CW'(DEPTH - 2);
  assign head_valid = count != '0;
  assign head       = mem[rptr];
  assign count_next = count + CW'(push.cnt) - CW'(pop);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wptr] <= push.first;
    if (push.cnt == 2'd2) mem[wptr_inc] <= push.second;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      count <= count_next;
      if (pop) rptr <= inc(rptr);
      if (push.cnt == 2'd1) wptr <= wptr_inc;
      else if (push.cnt == 2'd2) wptr <= inc(wptr_inc);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0) else $error("pop from empty job queue");

  a_push_has_room: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> room) else $error("push without two free slots");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("job queue overflow");

  a_double_push: assert property (@(posedge clk) disable iff (rst)
    push.cnt == 2'd2 && !pop |=> count == $past(count) + CW'(2))
    else $error("double push lost a job");

endmodule

`default_nettype wire

### rtl/cse_back.sv
// Back end: walks the characters of the head job and drives the output
// register. Uses cse_pkg and cse_out_if.
`default_nettype none

module cse_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire cse_pkg::job_t  head,
  output logic                pop,
  cse_out_if.source           esc
);

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] idx;
  logic       load;
  logic       job_end;

  assign load    = !out_valid || esc.ready;
  assign job_end = ({1'b0, idx} == head.len - 3'd1);
  assign pop     = load && head_valid && job_end;

  assign esc.valid    = out_valid;
  assign esc.out_byte = out_byte;
  assign esc.run_last = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) idx <= job_end ? 2'd0 : idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte <= head.chars[idx];
      out_last <= head.last && job_end;
    end
  end

endmodule

`default_nettype wire

### rtl/c_string_escape_encoder.sv
// Top level of the C string escape encoder: front, job queue and back.
// Uses cse_pkg, cse_in_if, cse_out_if, cse_front, cse_queue, cse_back.
//
// Raw bytes enter on raw at up to one word per cycle while the job queue
// has two free entries; each input word yields zero to eight escaped
// characters on esc, the last one flagged by run_last. The output port
// sends one character per cycle while esc.ready is high, so sustained
// throughput is set by the back end and the characters each word yields:
// one for a printable byte, two to four for an escaped one, so at most
// four per word once a string is under way; the word that ends a string
// also flushes the held byte and can yield eight. The first byte of each
// string is held one word for lookahead.
`default_nettype none

module c_string_escape_encoder #(
  parameter int QUEUE_DEPTH = cse_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  cse_in_if.sink     raw,
  cse_out_if.source  esc
);

  cse_pkg::push_t push;
  cse_pkg::job_t  head;
  logic           room;
  logic           head_valid;
  logic           pop;

  cse_front u_front (
    .clk  (clk),
    .rst  (rst),
    .raw  (raw),
    .room (room),
    .push (push)
  );

  cse_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .room       (room),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  cse_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .esc        (esc)
  );

endmodule

`default_nettype wire

### test/escape_checker.sv
// Escape checker: watches the raw and esc channels of the escape encoder,
// predicts the escaped characters and compares them. Uses cse_pkg, cse_in_if, cse_out_if.
module escape_checker (
  input  logic clk,
  input  logic rst,
  cse_in_if    raw,
  cse_out_if   esc,
  output int   fail_count,
  output int   chars_pending
);

  localparam logic [7:0] NUL_CHAR = 8'h00;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } esc_char_t;

  esc_char_t  expected_chars[$];
  logic [7:0] word_chars[$];
  logic [7:0] held_byte;
  logic       held_ok;
  esc_char_t  want;

  initial begin
    fail_count    = 0;
    chars_pending = 0;
    held_byte     = 8'h00;
    held_ok       = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $realtime, what);
    fail_count = fail_count + 1;
  endtask

  function automatic logic [7:0] letter_for(input logic [7:0] c);
    case (c)
      8'h09:   return "t";
      8'h0B:   return "v";
      8'h08:   return "b";
      8'h0D:   return "r";
      8'h0C:   return "f";
      8'h07:   return "a";
      8'h0A:   return "n";
      8'h5C:   return 8'h5C;
      8'h27:   return 8'h27;
      8'h22:   return 8'h22;
      default: return cse_pkg::NO_LETTER;
    endcase
  endfunction

  task automatic escape_byte(input logic [7:0] c, input logic [7:0] next);
    logic [7:0] e;
    logic       full;
    e    = letter_for(c);
    full = (next >= cse_pkg::CHAR_ZERO) && (next <= cse_pkg::CHAR_SEVEN);
    if (e != cse_pkg::NO_LETTER) begin
      word_chars.push_back(cse_pkg::CHAR_BSLASH);
      word_chars.push_back(e);
    end else if (c >= 8'h20 && c <= 8'h7E) begin
      word_chars.push_back(c);
    end else begin
      word_chars.push_back(cse_pkg::CHAR_BSLASH);
      if (c[7:6] != 2'd0 || full) begin
        word_chars.push_back(cse_pkg::CHAR_ZERO + {6'd0, c[7:6]});
        full = 1'b1;
      end
      if (c[5:3] != 3'd0 || full)
        word_chars.push_back(cse_pkg::CHAR_ZERO + {5'd0, c[5:3]});
      word_chars.push_back(cse_pkg::CHAR_ZERO + {5'd0, c[2:0]});
    end
  endtask

  task automatic predict_word(input logic [7:0] b, input logic eos);
    esc_char_t x;
    word_chars.delete();
    if (held_ok)
      escape_byte(held_byte, b);
    if (eos) begin
      escape_byte(b, NUL_CHAR);
      held_ok   = 1'b0;
      held_byte = 8'h00;
    end else begin
      held_byte = b;
      held_ok   = 1'b1;
    end
    foreach (word_chars[i]) begin
      x.ch   = word_chars[i];
      x.last = (i == word_chars.size() - 1);
      expected_chars.push_back(x);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_ok   = 1'b0;
      held_byte = 8'h00;
      expected_chars.delete();
    end else begin
      if (esc.valid && esc.ready) begin
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char 0x%02h", esc.out_byte));
        end else begin
          want = expected_chars.pop_front();
          if (esc.out_byte !== want.ch)
            report_mismatch($sformatf("out_byte 0x%02h, want 0x%02h",
                                      esc.out_byte, want.ch));
          if (esc.run_last !== want.last)
            report_mismatch($sformatf("run_last %b, want %b on char 0x%02h",
                                      esc.run_last, want.last, want.ch));
        end
      end
      if (raw.valid && raw.ready)
        predict_word(raw.in_byte, raw.end_of_string);
    end
    chars_pending = expected_chars.size();
  end

endmodule

### test/c_string_escape_encoder_tb.sv
// Testbench top for c_string_escape_encoder: clock, reset, string stimulus,
// output backpressure and verdict. Uses cse_pkg, both channel interfaces, escape_checker.
module c_string_escape_encoder_tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   chars_pending;
  int   stall_cycles = 0;
  logic idle_on = 1'b1;
  int   sent;
  int   len;

  cse_in_if  raw ();
  cse_out_if esc ();

  c_string_escape_encoder dut (
    .clk (clk),
    .rst (rst),
    .raw (raw),
    .esc (esc)
  );

  escape_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .raw           (raw),
    .esc           (esc),
    .fail_count    (fail_count),
    .chars_pending (chars_pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    esc.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_cycles > 0) begin
        esc.ready <= 1'b0;
        stall_cycles = stall_cycles - 1;
      end else begin
        esc.ready <= !idle_on || ($urandom_range(99) >= 37);
      end
    end
  end

  task automatic send_word(input logic [7:0] b, input logic eos);
    while (idle_on && $urandom_range(99) < 37) begin
      raw.valid <= 1'b0;
      @(posedge clk);
    end
    raw.valid         <= 1'b1;
    raw.in_byte       <= b;
    raw.end_of_string <= eos;
    @(posedge clk);
    while (!raw.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    raw.valid <= 1'b0;
    @(posedge clk);
    wait (chars_pending == 0);
    @(posedge clk);
  endtask

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(4))
      0:       return cse_pkg::CHAR_ZERO + 8'($urandom_range(9));
      1:       return 8'($urandom_range(8'h1F));
      2:       return 8'($urandom_range(8'h20, 8'h7F));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    raw.valid         <= 1'b0;
    raw.in_byte       <= 8'h00;
    raw.end_of_string <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // single-byte strings at the byte extremes
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b1);
    // octal kept full before a following octal digit
    send_word(8'h01, 1'b0);
    send_word(cse_pkg::CHAR_SEVEN, 1'b1);
    // every letter escape in one string
    send_word(8'h09, 1'b0);
    send_word(8'h0B, 1'b0);
    send_word(8'h08, 1'b0);
    send_word(8'h0D, 1'b0);
    send_word(8'h0C, 1'b0);
    send_word(8'h07, 1'b0);
    send_word(8'h0A, 1'b0);
    send_word(cse_pkg::CHAR_BSLASH, 1'b0);
    send_word(8'h27, 1'b0);
    send_word(8'h22, 1'b1);
    // printable edges, NUL mid-string, octal before non-digit and digit
    send_word(8'h20, 1'b0);
    send_word(8'h7E, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h01, 1'b0);
    send_word(8'h2F, 1'b0);
    send_word(8'h05, 1'b0);
    send_word(cse_pkg::CHAR_ZERO, 1'b1);
    wait_drained();

    sent = 0;
    while (sent < 320) begin
      len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 12);
      for (int k = 0; k < len; k++) begin
        if (sent == 90)
          stall_cycles = 150;
        if (sent == 160)
          wait_drained();
        idle_on = !(sent >= 200 && sent < 260);
        send_word(pick_byte(), k == len - 1);
        sent++;
      end
    end
    idle_on = 1'b1;
    wait_drained();
    repeat (20) @(posedge clk);

    if (fail_count == 0 && chars_pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
